@@ rtl/rpl_pkg.sv @@
// Package for the ranked preference list core.
// Request codes, sequencer states, field widths and cell bus types.
`timescale 1ns / 1ps

package rpl_pkg;

  localparam int VERTEX_W = 16;
  localparam int RANK_W   = 16;
  localparam int REQ_W    = 3;
  localparam int RPL_DEPTH = 64;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  // rank of an absent vertex, one above every stored rank
  localparam logic [RANK_W:0]   RANK_INF = {1'b1, {RANK_W{1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR    = 3'd0,
    REQ_APPEND   = 3'd1,
    REQ_COMPARE  = 3'd2,
    REQ_RESTRICT = 3'd3,
    REQ_ADVANCE  = 3'd4,
    REQ_QUERY    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_REPORT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic                cmp;
    logic [VERTEX_W-1:0] key_a;
    logic [VERTEX_W-1:0] key_b;
    logic [VERTEX_W-1:0] wr_vertex;
    logic [RANK_W-1:0]   wr_rank;
  } cell_bus_t;

  // handed from each cell to the next: a match was seen further up
  typedef struct packed {
    logic found_a;
    logic found_b;
  } chain_t;

endpackage

@@ rtl/ranked_preference_list_core.sv @@
// Ranked preference list core: a row of entry cells with a request sequencer.
// A request is taken only in idle; the cells register their matches, the apply
// state resolves the first-match chain and updates state, and the report state
// loads the head readout into the output register, which out_stall can delay.
// Reset clears counters, head, end and the output valid; entry cells are
// undefined until appended.
`timescale 1ns / 1ps

module ranked_preference_list_core #(
  parameter int  LIST_DEPTH = rpl_pkg::RPL_DEPTH,
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpl_pkg::REQ_W-1:0]     req_type,
  input  logic [rpl_pkg::VERTEX_W-1:0]  vertex_a,
  input  logic [rpl_pkg::VERTEX_W-1:0]  vertex_b,
  input  logic                          keep_rank,
  input  logic                          tie_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          better,
  output logic [rpl_pkg::VERTEX_W-1:0]  head_vertex,
  output logic                          head_valid,
  output logic [CNT_W-1:0]              list_size,
  output logic                          overflow
);
  import rpl_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);

  state_t state, state_next;

  logic [REQ_W-1:0]    req_q;
  logic [VERTEX_W-1:0] vertex_q;
  logic                same_q;
  logic                tie_q;

  logic [CNT_W-1:0]  stored_count, stored_count_next;
  logic [CNT_W-1:0]  head_index, head_index_next;
  logic [CNT_W-1:0]  end_index, end_index_next;
  logic [RANK_W-1:0] rank_counter, rank_counter_next;
  logic              better_r, better_next;
  logic              overflow_r, overflow_next;

  logic in_fire, apply, load_out, append_do;
  logic [RANK_W-1:0] rank_new;

  cell_bus_t bus;
  chain_t    chain [0:LIST_DEPTH];
  logic [LIST_DEPTH-1:0] first_a, first_b, live, wr;
  logic [VERTEX_W-1:0]   cell_vertex [0:LIST_DEPTH-1];
  logic [RANK_W-1:0]     cell_rank   [0:LIST_DEPTH-1];

  logic [RANK_W-1:0]   rank_a, rank_b;
  logic [IDX_W-1:0]    idx_a;
  logic [RANK_W:0]     ra, rb;
  logic [VERTEX_W-1:0] head_sel;
  logic                hv_ok;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign apply    = (state == ST_APPLY);
  assign load_out = (state == ST_REPORT) && (!out_valid || !out_stall);

  // cell row
  assign chain[0] = '0;
  assign bus.cmp       = in_fire;
  assign bus.key_a     = vertex_a;
  assign bus.key_b     = vertex_b;
  assign bus.wr_vertex = vertex_q;
  assign bus.wr_rank   = rank_new;

  assign append_do = apply && (req_q == REQ_APPEND)
                     && (stored_count != CNT_W'(LIST_DEPTH));
  assign rank_new  = (!same_q && rank_counter != RANK_MAX)
                     ? rank_counter + RANK_W'(1) : rank_counter;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    assign live[g] = CNT_W'(g) < end_index;
    assign wr[g]   = append_do && (stored_count[IDX_W-1:0] == IDX_W'(g));
    rpl_cell u_cell (
      .clk       (clk),
      .bus       (bus),
      .wr        (wr[g]),
      .live      (live[g]),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .first_a   (first_a[g]),
      .first_b   (first_b[g]),
      .vertex    (cell_vertex[g]),
      .rank      (cell_rank[g])
    );
  end

  // one-hot selects from the row
  always_comb begin
    rank_a   = '0;
    rank_b   = '0;
    idx_a    = '0;
    head_sel = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first_a[i]) begin
        rank_a = rank_a | cell_rank[i];
        idx_a  = idx_a | IDX_W'(i);
      end
      if (first_b[i]) rank_b = rank_b | cell_rank[i];
      if (head_index == CNT_W'(i)) head_sel = head_sel | cell_vertex[i];
    end
  end

  assign ra = chain[LIST_DEPTH].found_a ? {1'b0, rank_a} : RANK_INF;
  assign rb = chain[LIST_DEPTH].found_b ? {1'b0, rank_b} : RANK_INF;

  // state updates
  always_comb begin
    stored_count_next = stored_count;
    head_index_next   = head_index;
    end_index_next    = end_index;
    rank_counter_next = rank_counter;
    better_next       = better_r;
    overflow_next     = overflow_r;
    if (apply) begin
      better_next   = 1'b0;
      overflow_next = 1'b0;
      case (req_q)
        REQ_CLEAR: begin
          stored_count_next = '0;
          head_index_next   = '0;
          end_index_next    = '0;
        end
        REQ_APPEND: begin
          if (append_do) begin
            rank_counter_next = rank_new;
            stored_count_next = stored_count + CNT_W'(1);
            end_index_next    = stored_count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
        end
        REQ_COMPARE: begin
          better_next = tie_q ? (ra <= rb) : (ra < rb);
        end
        REQ_RESTRICT: begin
          if (chain[LIST_DEPTH].found_a) end_index_next = CNT_W'(idx_a) + CNT_W'(1);
        end
        REQ_ADVANCE: begin
          if (head_index < end_index) head_index_next = head_index + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_REPORT;
      ST_REPORT: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign hv_ok = head_index < end_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      head_index   <= '0;
      end_index    <= '0;
      rank_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      head_index   <= head_index_next;
      end_index    <= end_index_next;
      rank_counter <= rank_counter_next;
      if (load_out)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q    <= req_type;
      vertex_q <= vertex_a;
      same_q   <= keep_rank;
      tie_q    <= tie_mode;
    end
    better_r   <= better_next;
    overflow_r <= overflow_next;
    if (load_out) begin
      better      <= better_r;
      overflow    <= overflow_r;
      head_valid  <= hv_ok;
      head_vertex <= hv_ok ? head_sel : '0;
      list_size   <= hv_ok ? end_index - head_index : '0;
    end
  end

endmodule

@@ rtl/rpl_cell.sv @@
// One entry cell of the preference list: vertex, rank and match flags.
// Depends on rpl_pkg; passes the first-match chain to its neighbor.
`timescale 1ns / 1ps

module rpl_cell (
  input  logic                          clk,
  input  rpl_pkg::cell_bus_t            bus,
  input  logic                          wr,
  input  logic                          live,
  input  rpl_pkg::chain_t               chain_in,
  output rpl_pkg::chain_t               chain_out,
  output logic                          first_a,
  output logic                          first_b,
  output logic [rpl_pkg::VERTEX_W-1:0]  vertex,
  output logic [rpl_pkg::RANK_W-1:0]    rank
);
  import rpl_pkg::*;

  logic match_a;
  logic match_b;

  always_ff @(posedge clk) begin
    if (wr) begin
      vertex <= bus.wr_vertex;
      rank   <= bus.wr_rank;
    end
    if (bus.cmp) begin
      match_a <= live && (vertex == bus.key_a);
      match_b <= live && (vertex == bus.key_b);
    end
  end

  assign first_a           = match_a && !chain_in.found_a;
  assign first_b           = match_b && !chain_in.found_b;
  assign chain_out.found_a = chain_in.found_a || match_a;
  assign chain_out.found_b = chain_in.found_b || match_b;

endmodule
